// ===== src/fwar_pkg.sv =====
// ----------------------------------------------------------------------------
// fwar_pkg: shared types and constants of the admission ramp
// Command and phase codes, queue item layout, configuration indexes.
// ----------------------------------------------------------------------------
package fwar_pkg;

  // Unit id space and supported requesters
  localparam int ID_W      = 6;
  localparam int ID_SPACE  = 1 << ID_W;
  localparam int NUM_UNITS = 64;
  localparam int LEN_W     = ID_W + 1;

  // Configuration widths
  localparam int UPW_W      = 8;
  localparam int WT_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Front queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_ENABLE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS_PER_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS     = 2'd2;

  typedef enum logic [1:0] {
    CMD_REQ    = 2'd0,
    CMD_UNBLK  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_INIT  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOK,
    B_REL
  } bstate_t;

  typedef enum logic [1:0] {
    WL_NONE,
    WL_DROP,
    WL_POP,
    WL_APPEND
  } wl_op_t;

  // Classified command as it travels from front to back
  typedef struct packed {
    cmd_t            cmd;
    logic [ID_W-1:0] unit;
    logic            bad;
  } item_t;

endpackage

// ===== src/fwar_front.sv =====
// ----------------------------------------------------------------------------
// fwar_front: command intake and classification
// Accepts input transactions, flags units outside the supported range and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module fwar_front import fwar_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_cmd,
  input  logic [ID_W-1:0] in_unit_id,
  output logic            q_valid,
  output item_t           q_item,
  input  logic            q_pop
);

  item_t             q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push;
  item_t             cls;

  // Classify the incoming command
  always_comb begin
    cls.cmd  = cmd_t'(in_cmd);
    cls.unit = in_unit_id;
    cls.bad  = (cls.cmd != CMD_TICK) && (32'(in_unit_id) >= NUM_UNITS);
  end

  assign in_stall = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];

  // Queue pointers
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== src/fwar_back.sv =====
// ----------------------------------------------------------------------------
// fwar_back: admission engine
// Holds configuration, window counters, unit phase memory and the ordered
// wait list; executes queued commands and drives the result register.
// ----------------------------------------------------------------------------
module fwar_back import fwar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ID_W-1:0]       out_unit_out,
  output logic                  out_must_wait,
  output logic                  out_released,
  output logic                  out_status,
  output logic                  out_last
);

  bstate_t          state_r, state_nxt;
  item_t            cur_r, cur_nxt;

  logic             en_r, en_nxt;
  logic [UPW_W-1:0] upw_r, upw_nxt;
  logic [WT_W-1:0]  wt_r, wt_nxt;
  logic             active_r, active_nxt;
  logic [UPW_W-1:0] wc_r, wc_nxt;
  logic [WT_W-1:0]  tl_r, tl_nxt;
  logic             want;

  // Phase memory with per-entry valid bits
  phase_t           ph_mem [ID_SPACE];
  logic [ID_SPACE-1:0] ph_vld_r;
  phase_t           ph_rd_r;
  logic             ph_rd_en;
  logic             ph_we;
  logic [ID_W-1:0]  ph_waddr;
  phase_t           ph_wdata;

  // Wait list cells
  logic [ID_W-1:0]  wl_r   [ID_SPACE];
  logic [ID_W-1:0]  wl_nxt [ID_SPACE];
  logic [ID_W-1:0]  wl_up  [ID_SPACE];
  logic [LEN_W-1:0] wl_len_r, wl_len_nxt;
  wl_op_t           wl_op;
  logic [ID_SPACE-1:0] match;
  logic [ID_SPACE-1:0] pre [ID_W+1];
  logic [ID_SPACE-1:0] kill;

  // Result register
  logic             out_valid_r;
  logic [ID_W-1:0]  out_unit_r;
  logic             out_wait_r, out_rel_r, out_st_r, out_last_r;
  logic             res_load;
  logic [ID_W-1:0]  res_unit;
  logic             res_wait, res_rel, res_st, res_last;
  logic             out_free;
  logic             rel_go;

  assign out_free = !out_valid_r || !out_stall;
  assign rel_go   = (wl_len_r != '0) && (!active_r || (wc_r < upw_r));

  // Command sequencing and configuration
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    q_pop      = 1'b0;
    ph_rd_en   = 1'b0;
    ph_we      = 1'b0;
    ph_waddr   = cur_r.unit;
    ph_wdata   = PH_READY;
    wl_op      = WL_NONE;
    en_nxt     = en_r;
    upw_nxt    = upw_r;
    wt_nxt     = wt_r;
    active_nxt = active_r;
    wc_nxt     = wc_r;
    tl_nxt     = tl_r;
    want       = 1'b0;
    res_load   = 1'b0;
    res_unit   = cur_r.unit;
    res_wait   = 1'b0;
    res_rel    = 1'b0;
    res_st     = 1'b0;
    res_last   = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          if (q_item.cmd == CMD_TICK) begin
            if (active_r && (tl_r > WT_W'(1))) begin
              tl_nxt = tl_r - 1'b1;
            end else begin
              if (active_r) begin
                tl_nxt = wt_r;
                wc_nxt = '0;
              end
              state_nxt = B_REL;
            end
          end else begin
            ph_rd_en  = 1'b1;
            state_nxt = B_LOOK;
          end
        end
      end

      B_LOOK: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_last  = 1'b1;
          state_nxt = B_IDLE;
          if (!cur_r.bad) begin
            case (cur_r.cmd)
              CMD_REQ: begin
                if (!active_r) begin
                  if (ph_rd_r == PH_WAIT) wl_op = WL_DROP;
                  ph_we   = 1'b1;
                  res_rel = (ph_rd_r != PH_READY);
                end else if (ph_rd_r == PH_WAIT) begin
                  res_wait = 1'b1;
                end else if (ph_rd_r == PH_READY) begin
                  res_wait = 1'b0;
                end else if (wc_r < upw_r) begin
                  wc_nxt  = wc_r + 1'b1;
                  ph_we   = 1'b1;
                  res_rel = 1'b1;
                end else begin
                  ph_we    = 1'b1;
                  ph_wdata = PH_WAIT;
                  wl_op    = WL_APPEND;
                  res_wait = 1'b1;
                end
              end
              CMD_UNBLK: begin
                if (ph_rd_r != PH_WAIT) begin
                  res_st = 1'b1;
                end else begin
                  wl_op   = WL_DROP;
                  ph_we   = 1'b1;
                  res_rel = 1'b1;
                end
              end
              CMD_REMOVE: begin
                if (ph_rd_r == PH_WAIT) wl_op = WL_DROP;
                ph_we    = 1'b1;
                ph_wdata = PH_INIT;
              end
              default: begin
                res_st = 1'b0;
              end
            endcase
          end
        end
      end

      B_REL: begin
        if (!rel_go) begin
          state_nxt = B_IDLE;
        end else if (out_free) begin
          wl_op    = WL_POP;
          ph_we    = 1'b1;
          ph_waddr = wl_r[0];
          res_load = 1'b1;
          res_unit = wl_r[0];
          res_rel  = 1'b1;
          if (active_r) wc_nxt = wc_r + 1'b1;
          res_last = (wl_len_r == LEN_W'(1)) ||
                     (active_r && (({1'b0, wc_r} + 9'd1) >= {1'b0, upw_r}));
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // Register writes re-evaluate activity
    if (cfg_we) begin
      case (cfg_index)
        CFG_RAMP_ENABLE:      en_nxt  = cfg_wdata[0];
        CFG_UNITS_PER_WINDOW: upw_nxt = cfg_wdata[UPW_W-1:0];
        CFG_WINDOW_TICKS:     wt_nxt  = cfg_wdata[WT_W-1:0];
        default:              en_nxt  = en_r;
      endcase
      want = en_nxt && (upw_nxt != '0) && (wt_nxt != '0);
      if (!want && active_r) begin
        active_nxt = 1'b0;
        wc_nxt     = '0;
      end else if (want && !active_r) begin
        active_nxt = 1'b1;
        tl_nxt     = wt_nxt;
      end
    end
  end

  // Wait list: match, prefix mask of entries at or behind the match, shift
  always_comb begin
    for (int i = 0; i < ID_SPACE; i++) begin
      match[i] = (LEN_W'(i) < wl_len_r) && (wl_r[i] == cur_r.unit);
    end
    pre[0] = match;
    for (int s = 0; s < ID_W; s++) begin
      pre[s+1] = pre[s] | (pre[s] << (1 << s));
    end
    kill = pre[ID_W];

    for (int i = 0; i < ID_SPACE - 1; i++) begin
      wl_up[i] = wl_r[i+1];
    end
    wl_up[ID_SPACE-1] = wl_r[ID_SPACE-1];

    wl_len_nxt = wl_len_r;
    for (int i = 0; i < ID_SPACE; i++) begin
      wl_nxt[i] = wl_r[i];
      case (wl_op)
        WL_DROP:   if (kill[i]) wl_nxt[i] = wl_up[i];
        WL_POP:    wl_nxt[i] = wl_up[i];
        WL_APPEND: if (LEN_W'(i) == wl_len_r) wl_nxt[i] = cur_r.unit;
        default:   wl_nxt[i] = wl_r[i];
      endcase
    end

    case (wl_op)
      WL_DROP:   if (kill[ID_SPACE-1]) wl_len_nxt = wl_len_r - 1'b1;
      WL_POP:    wl_len_nxt = wl_len_r - 1'b1;
      WL_APPEND: if (wl_len_r < LEN_W'(ID_SPACE)) wl_len_nxt = wl_len_r + 1'b1;
      default:   wl_len_nxt = wl_len_r;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      en_r        <= 1'b0;
      upw_r       <= '0;
      wt_r        <= '0;
      active_r    <= 1'b0;
      wc_r        <= '0;
      tl_r        <= '0;
      wl_len_r    <= '0;
      ph_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      en_r     <= en_nxt;
      upw_r    <= upw_nxt;
      wt_r     <= wt_nxt;
      active_r <= active_nxt;
      wc_r     <= wc_nxt;
      tl_r     <= tl_nxt;
      wl_len_r <= wl_len_nxt;
      if (ph_we) ph_vld_r[ph_waddr] <= 1'b1;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    for (int i = 0; i < ID_SPACE; i++) begin
      wl_r[i] <= wl_nxt[i];
    end
    if (res_load) begin
      out_unit_r <= res_unit;
      out_wait_r <= res_wait;
      out_rel_r  <= res_rel;
      out_st_r   <= res_st;
      out_last_r <= res_last;
    end
  end

  // Phase memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ph_we) begin
      ph_mem[ph_waddr] <= ph_wdata;
    end
    if (ph_rd_en) begin
      ph_rd_r <= ph_vld_r[q_item.unit] ? ph_mem[q_item.unit] : PH_INIT;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_unit_out  = out_unit_r;
  assign out_must_wait = out_wait_r;
  assign out_released  = out_rel_r;
  assign out_status    = out_st_r;
  assign out_last      = out_last_r;

endmodule

// ===== src/fixed_window_admission_ramp.sv =====
// ----------------------------------------------------------------------------
// fixed_window_admission_ramp: fixed-window admission limiter
// Admits requesting units up to a per-window budget, queues the rest in
// order and releases them on window expiry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one command per transaction:
//   request, unblock, remove or tick. A two-entry queue decouples intake
//   from the engine, so in_stall rises only when that queue is full.
//   Result channel (out_valid/out_stall) delivers one transaction per
//   result; out_last marks the final result of a command. Request, unblock
//   and remove give one result each and are handled one at a time: the
//   engine reads the phase memory, then updates it. A tick that ends a
//   window, or any tick while the ramp is inactive, releases waiting
//   units, one wait list pop per cycle while the result register is free.
//   A tick that releases nothing gives no result. Configuration is
//   written through cfg_we/cfg_index/cfg_wdata while idle; the user must
//   keep to this, as the block itself does not enforce it.
//   Reset clears configuration, counters, the wait list and all phases.
//   While the receiver stalls the result register holds and the engine
//   waits, and commands keep filling the queue until it is full.
// ----------------------------------------------------------------------------
module fixed_window_admission_ramp import fwar_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [ID_W-1:0]       in_unit_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ID_W-1:0]       out_unit_out,
  output logic                  out_must_wait,
  output logic                  out_released,
  output logic                  out_status,
  output logic                  out_last
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Intake and classification
  fwar_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_unit_id (in_unit_id),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Admission engine
  fwar_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_unit_out  (out_unit_out),
    .out_must_wait (out_must_wait),
    .out_released  (out_released),
    .out_status    (out_status),
    .out_last      (out_last)
  );

endmodule
